### hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [VALUE_W-1:0] value;
	} spq_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] head_value;
		logic [COUNT_W-1:0]        count;
	} spq_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INS,
		ST_PUT,
		ST_RESULT
	} spq_state_t;

endpackage
`default_nettype wire

### hdl/spq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface spq_req_if;
	import spq_pkg::*;

	logic     valid;
	logic     ready;
	spq_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;

	logic     valid;
	logic     ready;
	spq_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/spq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Descending sorted list in one RAM with insert, remove and find commands.
// ----------------------------------------------------------------------------
// Insert walks from the tail, shifting one entry per cycle.
// Remove and find walk from the head.
// The controller returns to idle after each result, and walks are paced by the single RAM
//   read port; the response register admits a request while a result waits.
// Reset clears the count and control state; RAM contents stay undefined.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	spq_state_t state_q, state_d;

	logic [CMD_W-1:0]          cmd_q, cmd_d;
	logic signed [VALUE_W-1:0] value_q, value_d;
	logic [AW-1:0]             ptr_q, ptr_d;
	logic [AW-1:0]             pos_q, pos_d;
	logic                      found_q, found_d;
	logic [STATUS_W-1:0]       status_q, status_d;
	logic [CW-1:0]             cnt_q, cnt_d;
	logic signed [VALUE_W-1:0] head_q;
	logic                      rsp_valid_q;
	spq_rsp_t                  rsp_q;

	logic                      we, re, rsp_load;
	logic [AW-1:0]             waddr, raddr;
	logic [VALUE_W-1:0]        wdata, rd_data;

	logic          slot_free, is_full, is_empty, at_tail, eq, ge;
	logic [AW-1:0] last;

	spq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign is_full   = cnt_q == CW'(DEPTH);
	assign is_empty  = cnt_q == '0;
	assign last      = AW'(cnt_q - 1'b1);
	assign at_tail   = ptr_q == last;
	assign eq        = rd_data == value_q;
	assign ge        = value_q >= $signed(rd_data);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.data.cmd)
						CMD_INSERT: begin
							if (is_full) state_d = ST_RESULT;
							else if (is_empty) state_d = ST_PUT;
							else state_d = ST_INS;
						end
						CMD_REMOVE, CMD_FIND: begin
							state_d = is_empty ? ST_RESULT : ST_SCAN;
						end
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_SCAN: begin
				if (at_tail || (!found_q && eq && cmd_q == CMD_FIND)) state_d = ST_RESULT;
			end
			ST_INS: begin
				if (!(ge && ptr_q != '0)) state_d = ST_PUT;
			end
			ST_PUT:    state_d = ST_RESULT;
			ST_RESULT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		req.ready = 1'b0;
		we        = 1'b0;
		waddr     = ptr_q;
		wdata     = rd_data;
		re        = 1'b0;
		raddr     = ptr_q;
		rsp_load  = 1'b0;
		cmd_d     = cmd_q;
		value_d   = value_q;
		ptr_d     = ptr_q;
		pos_d     = pos_q;
		found_d   = found_q;
		status_d  = status_q;
		cnt_d     = cnt_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					cmd_d    = req.data.cmd;
					value_d  = req.data.value;
					found_d  = 1'b0;
					pos_d    = '0;
					status_d = STATUS_NOTFOUND;
					case (req.data.cmd)
						CMD_INSERT: begin
							if (is_full) begin
								status_d = STATUS_FULL;
							end else if (!is_empty) begin
								re    = 1'b1;
								raddr = last;
								ptr_d = last;
							end
						end
						CMD_REMOVE, CMD_FIND: begin
							if (!is_empty) begin
								re    = 1'b1;
								raddr = '0;
								ptr_d = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (found_q) begin
					we    = 1'b1;
					waddr = AW'(ptr_q - 1'b1);
					wdata = rd_data;
				end else if (eq) begin
					found_d  = 1'b1;
					pos_d    = ptr_q;
					status_d = STATUS_OK;
				end
				if (at_tail) begin
					if (found_q || (eq && cmd_q == CMD_REMOVE)) cnt_d = CW'(cnt_q - 1'b1);
				end else if (found_q || !eq || cmd_q == CMD_REMOVE) begin
					re    = 1'b1;
					raddr = AW'(ptr_q + 1'b1);
					ptr_d = AW'(ptr_q + 1'b1);
				end
			end
			ST_INS: begin
				if (ge) begin
					we    = 1'b1;
					waddr = AW'(ptr_q + 1'b1);
					wdata = rd_data;
					if (ptr_q == '0) begin
						pos_d = '0;
					end else begin
						re    = 1'b1;
						raddr = AW'(ptr_q - 1'b1);
						ptr_d = AW'(ptr_q - 1'b1);
					end
				end else begin
					pos_d = AW'(ptr_q + 1'b1);
				end
			end
			ST_PUT: begin
				we       = 1'b1;
				waddr    = pos_q;
				wdata    = value_q;
				cnt_d    = CW'(cnt_q + 1'b1);
				status_d = STATUS_OK;
			end
			ST_RESULT: begin
				rsp_load = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		value_q  <= value_d;
		ptr_q    <= ptr_d;
		pos_q    <= pos_d;
		status_q <= status_d;
		if (we && waddr == '0) head_q <= wdata;
		if (rsp_load) begin
			rsp_q.status     <= status_q;
			rsp_q.position   <= POS_W'(pos_q);
			rsp_q.head_value <= is_empty ? '0 : head_q;
			rsp_q.count      <= COUNT_W'(cnt_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != ST_IDLE)
		else $error("request accepted but controller stayed idle");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_SCAN || state_q == ST_INS || state_q == ST_PUT))
		else $error("RAM write outside a walk");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> CW'(waddr) <= cnt_q)
		else $error("RAM write beyond fill level");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == CW'($past(cnt_q) + 1'b1)
			|| cnt_q == CW'($past(cnt_q) - 1'b1)))
		else $error("count moved by more than one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> cnt_q <= CW'(DEPTH))
		else $error("count above depth");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sorted priority queue against a behavioral copy of its list.
// Each request transaction is applied to the copy when the block accepts it,
// and each response transaction is compared field by field in order. Both
// channels stall in random bursts, and the response side holds off once for a
// long stretch so that the block backs up into its request channel.
// ----------------------------------------------------------------------------
module tb_top;
	import spq_pkg::*;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned RANDOM_ITEMS = 430;
	localparam int unsigned CALM_ITEMS   = 60;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned DRAIN_CYCLES = 40;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

	class spq_scoreboard;
		logic signed [VALUE_W-1:0] entries [DEPTH];
		int unsigned fill;
		spq_rsp_t awaited_rsp [$];
		int unsigned mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function int locate(logic signed [VALUE_W-1:0] v);
			int i;
			for (i = 0; i < int'(fill); i++) begin
				if (entries[i] == v)
					return i;
			end
			return -1;
		endfunction

		function spq_rsp_t apply_command(spq_req_t r);
			spq_rsp_t o;
			int idx;
			int j;
			o.status = STATUS_NOTFOUND;
			o.position = '0;
			case (r.cmd)
				CMD_INSERT: begin
					if (fill >= DEPTH) begin
						o.status = STATUS_FULL;
					end else begin
						idx = 0;
						while (idx < int'(fill) && $signed(r.value) < $signed(entries[idx]))
							idx++;
						for (j = int'(fill); j > idx; j--)
							entries[j] = entries[j-1];
						entries[idx] = r.value;
						fill++;
						o.status = STATUS_OK;
						o.position = POS_W'(idx);
					end
				end
				CMD_REMOVE: begin
					idx = locate(r.value);
					if (idx >= 0) begin
						for (j = idx; j + 1 < int'(fill); j++)
							entries[j] = entries[j+1];
						fill--;
						o.status = STATUS_OK;
						o.position = POS_W'(idx);
					end
				end
				CMD_FIND: begin
					idx = locate(r.value);
					if (idx >= 0) begin
						o.status = STATUS_OK;
						o.position = POS_W'(idx);
					end
				end
				default: ;
			endcase
			o.head_value = (fill > 0) ? entries[0] : '0;
			o.count = COUNT_W'(fill);
			return o;
		endfunction

		function void accept_request(spq_req_t r);
			awaited_rsp.push_back(apply_command(r));
		endfunction

		function void check_response(spq_rsp_t got);
			spq_rsp_t exp;
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: unexpected response st=%0d pos=%0d head=%0d cnt=%0d",
						got.status, got.position, got.head_value, got.count);
				return;
			end
			exp = awaited_rsp.pop_front();
			if (got.status !== exp.status || got.position !== exp.position ||
			    got.head_value !== exp.head_value || got.count !== exp.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch @%0t: exp st=%0d pos=%0d head=%0d cnt=%0d, got st=%0d pos=%0d head=%0d cnt=%0d",
						$realtime, exp.status, exp.position, exp.head_value, exp.count,
						got.status, got.position, got.head_value, got.count);
			end
		endfunction

		function logic signed [VALUE_W-1:0] some_entry();
			return entries[$urandom_range(0, fill - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	bit long_hold;
	int unsigned idle_cycles;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	spq_scoreboard sb = new();

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// response first: a response can never belong to a request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.data);
			if (req_ch.valid && req_ch.ready)
				sb.accept_request(req_ch.data);
			if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
		spq_req_t r;
		r.cmd = c;
		r.value = v;
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value(bit from_list);
		logic signed [VALUE_W-1:0] common [8];
		int unsigned r;
		common = '{VAL_MAX, VAL_MIN, 0, -1, 1, 100, -100, 42};
		r = $urandom_range(0, 9);
		if (from_list && sb.fill > 0 && r < 5)
			return sb.some_entry();
		if (r < 7)
			return common[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(mix_t mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (r < 75) return CMD_INSERT;
				if (r < 85) return CMD_REMOVE;
				if (r < 97) return CMD_FIND;
			end
			MODE_DRAIN: begin
				if (r < 20) return CMD_INSERT;
				if (r < 70) return CMD_REMOVE;
				if (r < 95) return CMD_FIND;
			end
			default: begin
				if (r < 40) return CMD_INSERT;
				if (r < 70) return CMD_REMOVE;
				if (r < 95) return CMD_FIND;
			end
		endcase
		return CMD_UNUSED;
	endfunction

	initial begin
		mix_t mode;
		logic [CMD_W-1:0] c;
		arst_n = 1'b0;
		calm = 1'b0;
		long_hold = 1'b0;
		idle_cycles = 0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unused code, extremes, duplicates, head/tail/middle edits
		send_request(CMD_FIND, 0);
		send_request(CMD_REMOVE, 5);
		send_request(CMD_UNUSED, 7);
		send_request(CMD_INSERT, 0);
		send_request(CMD_INSERT, 0);
		send_request(CMD_INSERT, VAL_MAX);
		send_request(CMD_INSERT, VAL_MIN);
		send_request(CMD_INSERT, -1);
		send_request(CMD_FIND, VAL_MIN);
		send_request(CMD_FIND, 0);
		send_request(CMD_FIND, 12345);
		send_request(CMD_REMOVE, VAL_MIN);
		send_request(CMD_REMOVE, VAL_MAX);
		send_request(CMD_REMOVE, 0);
		send_request(CMD_INSERT, 32'sh5555_5555);
		send_request(CMD_INSERT, 32'shAAAA_AAAA);
		send_request(CMD_UNUSED, VAL_MIN);
		send_request(CMD_FIND, -1);
		send_request(CMD_REMOVE, 7);
		send_request(CMD_REMOVE, -1);
		send_request(CMD_REMOVE, 0);
		send_request(CMD_REMOVE, 32'sh5555_5555);
		send_request(CMD_REMOVE, 32'shAAAA_AAAA);

		mode = MODE_FILL;
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n != 0 && n % 30 == 0)
				mode = mix_t'($urandom_range(0, 2));
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if (n == 150)
				long_hold = 1'b1;
			c = pick_cmd(mode);
			send_request(c, pick_value(c != CMD_INSERT || $urandom_range(0, 2) == 0));
		end
		req_ch.valid <= 1'b0;

		while (sb.awaited_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited_rsp.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
